// ===== src/sha1_pkg.sv =====
// shared constants, types and round functions of the sha-1 byte stream hasher
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_FILL    = 6'd56;
    localparam logic [5:0] FULL_FILL   = 6'd63;
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [4:0] DIGEST_LAST = 5'd19;

    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic      absorb;
        t_byte_sel byte_sel;
        logic      count_bits;
        logic      capture_len;
        logic      start_block;
        logic      round_en;
        logic      chain_add;
        logic      emit_next;
        logic      reinit;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       emit_last;
    } t_dp_status;

    function automatic logic [31:0] f_logic(input logic [6:0] round,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] res;
        if (round < 7'd20) begin
            res = ((c ^ d) & b) ^ d;
        end else if (round < 7'd40) begin
            res = b ^ c ^ d;
        end else if (round < 7'd60) begin
            res = (b & c) | (d & (b | c));
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic logic [31:0] f_const(input logic [6:0] round);
        logic [31:0] res;
        if (round < 7'd20) begin
            res = K0;
        end else if (round < 7'd40) begin
            res = K1;
        end else if (round < 7'd60) begin
            res = K2;
        end else begin
            res = K3;
        end
        return res;
    endfunction

endpackage

// ===== src/sha1_in_if.sv =====
// input channel: message bytes and end of message requests
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// ===== src/sha1_out_if.sv =====
// output channel: digest bytes with last mark
interface sha1_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       last_byte;

    modport source (output valid, output digest_byte, output last_byte, input ready);
    modport sink   (input valid, input digest_byte, input last_byte, output ready);
endinterface

// ===== src/sha1_datapath.sv =====
// sha-1 datapath: block buffer, message schedule, round unit, chain and counters
module sha1_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_data_byte,
    input  sha1_pkg::t_dp_cmd    i_cmd,
    output sha1_pkg::t_dp_status o_status,
    output logic [7:0]           o_digest_byte,
    output logic                 o_last_byte
);

    logic [31:0] r_chain [5];
    logic [31:0] r_blk   [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_fill;
    logic [63:0] r_msg_bits;
    logic [63:0] r_len;
    logic [6:0]  r_round;
    logic [4:0]  r_emit_idx;

    logic [7:0]  in_byte;
    logic [31:0] w_next;
    logic [31:0] t_sum;
    logic [31:0] sel_word;

    always_comb begin
        unique case (i_cmd.byte_sel)
            sha1_pkg::SEL_DATA: in_byte = i_data_byte;
            sha1_pkg::SEL_PAD:  in_byte = sha1_pkg::PAD_BYTE;
            sha1_pkg::SEL_ZERO: in_byte = 8'h00;
            sha1_pkg::SEL_LEN:  in_byte = r_len[63:56];
            default:            in_byte = 8'h00;
        endcase
    end

    // schedule window: r_blk[0] is w[t], next word extends the window
    assign w_next = {r_blk[13][30:0] ^ r_blk[8][30:0] ^ r_blk[2][30:0] ^ r_blk[0][30:0],
                     r_blk[13][31] ^ r_blk[8][31] ^ r_blk[2][31] ^ r_blk[0][31]};

    assign t_sum = {r_a[26:0], r_a[31:27]} + sha1_pkg::f_logic(r_round, r_b, r_c, r_d)
                 + r_e + r_blk[0] + sha1_pkg::f_const(r_round);

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            for (int i = 0; i < 15; i++) begin
                r_blk[i] <= {r_blk[i][23:0], r_blk[i+1][31:24]};
            end
            r_blk[15] <= {r_blk[15][23:0], in_byte};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_blk[i] <= r_blk[i+1];
            end
            r_blk[15] <= w_next;
        end
        if (i_cmd.capture_len) begin
            r_len <= r_msg_bits;
        end else if (i_cmd.absorb && i_cmd.byte_sel == sha1_pkg::SEL_LEN) begin
            r_len <= {r_len[55:0], 8'h00};
        end
        if (i_cmd.start_block) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round_en) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_chain[0] <= sha1_pkg::H0;
            r_chain[1] <= sha1_pkg::H1;
            r_chain[2] <= sha1_pkg::H2;
            r_chain[3] <= sha1_pkg::H3;
            r_chain[4] <= sha1_pkg::H4;
            r_fill     <= '0;
            r_msg_bits <= '0;
            r_round    <= '0;
            r_emit_idx <= '0;
        end else begin
            if (i_cmd.chain_add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (i_cmd.absorb) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count_bits) begin
                r_msg_bits <= r_msg_bits + 64'd8;
            end
            if (i_cmd.start_block) begin
                r_round <= '0;
            end else if (i_cmd.round_en) begin
                r_round <= r_round + 7'd1;
            end
            if (i_cmd.emit_next) begin
                r_emit_idx <= r_emit_idx + 5'd1;
            end
        end
    end

    always_comb begin
        unique case (r_emit_idx[4:2])
            3'd0:    sel_word = r_chain[0];
            3'd1:    sel_word = r_chain[1];
            3'd2:    sel_word = r_chain[2];
            3'd3:    sel_word = r_chain[3];
            3'd4:    sel_word = r_chain[4];
            default: sel_word = '0;
        endcase
        unique case (r_emit_idx[1:0])
            2'd0:    o_digest_byte = sel_word[31:24];
            2'd1:    o_digest_byte = sel_word[23:16];
            2'd2:    o_digest_byte = sel_word[15:8];
            default: o_digest_byte = sel_word[7:0];
        endcase
    end

    assign o_last_byte         = (r_emit_idx == sha1_pkg::DIGEST_LAST);
    assign o_status.fill       = r_fill;
    assign o_status.round_last = (r_round == sha1_pkg::ROUND_LAST);
    assign o_status.emit_last  = (r_emit_idx == sha1_pkg::DIGEST_LAST);

endmodule

// ===== src/sha1_ctrl.sv =====
// sha-1 controller: byte intake, padding sequence, compression and digest emission
module sha1_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_mode,
    input  logic                 i_out_ready,
    input  sha1_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output sha1_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PAD80  = 7'b0000010,
        S_PADZ   = 7'b0000100,
        S_PADLEN = 7'b0001000,
        S_ROUND  = 7'b0010000,
        S_ADD    = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_state r_resume, n_resume;
    logic   full;

    assign full        = (i_status.fill == sha1_pkg::FULL_FILL);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_mode) begin
                        o_cmd.absorb     = 1'b1;
                        o_cmd.byte_sel   = sha1_pkg::SEL_DATA;
                        o_cmd.count_bits = 1'b1;
                        if (full) begin
                            o_cmd.start_block = 1'b1;
                            n_state           = S_ROUND;
                            n_resume          = S_IDLE;
                        end
                    end else begin
                        o_cmd.capture_len = 1'b1;
                        n_state           = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                o_cmd.absorb   = 1'b1;
                o_cmd.byte_sel = sha1_pkg::SEL_PAD;
                n_state        = S_PADZ;
                if (full) begin
                    o_cmd.start_block = 1'b1;
                    n_state           = S_ROUND;
                    n_resume          = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_status.fill == sha1_pkg::LEN_FILL) begin
                    n_state = S_PADLEN;
                end else begin
                    o_cmd.absorb   = 1'b1;
                    o_cmd.byte_sel = sha1_pkg::SEL_ZERO;
                    if (full) begin
                        o_cmd.start_block = 1'b1;
                        n_state           = S_ROUND;
                        n_resume          = S_PADZ;
                    end
                end
            end
            S_PADLEN: begin
                o_cmd.absorb   = 1'b1;
                o_cmd.byte_sel = sha1_pkg::SEL_LEN;
                if (full) begin
                    o_cmd.start_block = 1'b1;
                    n_state           = S_ROUND;
                    n_resume          = S_EMIT;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                n_state         = r_resume;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.reinit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resume <= S_IDLE;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
        end
    end

endmodule

// ===== src/sha1_byte_stream_hasher.sv =====
// sha-1 byte stream hasher top level
// usage:
//   i_in carries one request per message byte (mode 0) or an end of message
//   request (mode 1, data byte ignored). o_out returns the 20 digest bytes,
//   most significant first, last_byte set on the twentieth.
// timing:
//   a data byte is taken whenever i_in.ready is high; every 64th byte then
//   starts a compression (80 rounds on one round unit, then a chain add)
//   during which i_in.ready is low. an end of message request pads one
//   byte per cycle, except while a compression runs, up to the length
//   field (at most 64 bytes), steps into the length state, then adds the
//   length and one or two compressions before the first digest byte is
//   presented; then one per cycle while o_out.ready is high.
// stalls:
//   while o_out.ready is low the current digest byte holds; no new request
//   is taken until the whole digest has been delivered.
// reset:
//   synchronous active low reset loads the initial hash values and clears
//   the byte fill and bit count; the block returns to the same state after
//   each digest.
module sha1_byte_stream_hasher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           i_in,
    sha1_out_if.source        o_out
);

    sha1_pkg::t_dp_cmd    cmd;
    sha1_pkg::t_dp_status status;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    sha1_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.data_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_digest_byte (o_out.digest_byte),
        .o_last_byte   (o_out.last_byte)
    );

endmodule

// ===== test/tb_sha1_byte_stream_hasher.sv =====
// testbench for the sha-1 byte stream hasher: random messages checked against a digest predictor
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam int ITEM_TARGET = 180;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 100;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_digest_byte;

    class sha1_scoreboard;
        logic [31:0]  chain[5];
        logic [31:0]  block[16];
        logic [5:0]   fill;
        logic [63:0]  msg_bits;
        t_digest_byte digest_q[$];
        int           mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            chain = '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
            foreach (block[i]) block[i] = '0;
            fill     = '0;
            msg_bits = '0;
        endfunction

        function void compress();
            logic [31:0] w[80];
            logic [31:0] a, b, c, d, e, f, k, t, x;
            for (int r = 0; r < 16; r++) w[r] = block[r];
            for (int r = 16; r < 80; r++) begin
                x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
                w[r] = {x[30:0], x[31]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = sha1_pkg::K0;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = sha1_pkg::K1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = sha1_pkg::K2;
                end else begin
                    f = b ^ c ^ d;
                    k = sha1_pkg::K3;
                end
                t = {a[26:0], a[31:27]} + f + e + w[r] + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb(logic [7:0] value);
            block[fill[5:2]] = {block[fill[5:2]][23:0], value};
            if (fill == 6'd63) begin
                compress();
                fill = '0;
            end else begin
                fill++;
            end
        endfunction

        function void note_request(logic mode, logic [7:0] data);
            logic [63:0]  bit_len;
            t_digest_byte db;
            if (mode == MODE_APPEND) begin
                absorb(data);
                msg_bits += 64'd8;
            end else begin
                bit_len = msg_bits;
                absorb(sha1_pkg::PAD_BYTE);
                while (fill != sha1_pkg::LEN_FILL) absorb(8'h00);
                for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8*i -: 8]);
                for (int i = 0; i < 20; i++) begin
                    db.value = chain[i / 4][31 - 8*(i % 4) -: 8];
                    db.last  = (i == 19);
                    digest_q.push_back(db);
                end
                restart();
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_digest(logic [7:0] value, logic last);
            t_digest_byte want;
            if (digest_q.size() == 0) begin
                report($sformatf("digest byte %h last %b with nothing pending", value, last));
            end else begin
                want = digest_q.pop_front();
                if (value !== want.value)
                    report($sformatf("digest byte %h, expected %h", value, want.value));
                if (last !== want.last)
                    report($sformatf("last mark %b, expected %b", last, want.last));
            end
        endtask

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    bit   long_hold_req;
    int   requests_sent;
    int   cycles;

    sha1_scoreboard sb;

    sha1_in_if  req_if ();
    sha1_out_if dig_if ();

    sha1_byte_stream_hasher uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if.sink),
        .o_out   (dig_if.source)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic mode, input logic [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= mode;
        req_if.data_byte <= data;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_request(mode, data);
        requests_sent++;
    endtask

    always @(posedge clk) begin
        if (rst_n && dig_if.valid && dig_if.ready)
            sb.check_digest(dig_if.digest_byte, dig_if.last_byte);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // digest side: random stalls, plus one long hold-off so the input backs up
    initial begin
        bit hold_done;
        hold_done = 0;
        dig_if.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (long_hold_req && !hold_done) begin
                dig_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1;
            end else begin
                if (pick_gap() > 0) begin
                    dig_if.ready <= 1'b0;
                    repeat (pick_gap() + 1) @(posedge clk);
                end
                dig_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial begin
        int msg_len;
        sb               = new();
        cycles           = 0;
        requests_sent    = 0;
        calm             = 0;
        long_hold_req    = 0;
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.mode      <= MODE_APPEND;
        req_if.data_byte <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, the data byte on finish must be ignored
        send_request(MODE_FINISH, 8'hff);
        send_request(MODE_APPEND, 8'h00);
        send_request(MODE_FINISH, 8'h00);
        send_request(MODE_APPEND, 8'hff);
        send_request(MODE_FINISH, 8'h5a);
        send_request(MODE_APPEND, 8'h61);
        send_request(MODE_APPEND, 8'h62);
        send_request(MODE_APPEND, 8'h63);
        send_request(MODE_FINISH, 8'h01);
        send_request(MODE_APPEND, 8'h80);
        send_request(MODE_APPEND, 8'h7f);
        send_request(MODE_FINISH, 8'hc3);

        // 55 bytes pads within one block, 64 bytes needs a pad-only block
        for (int n = 0; requests_sent < ITEM_TARGET; n++) begin
            if (n == 0)
                msg_len = 55;
            else if (n == 1)
                msg_len = 64;
            else if ($urandom_range(0, 5) == 0)
                msg_len = $urandom_range(56, 63);
            else
                msg_len = $urandom_range(0, 9);
            // keep the request count near the target
            if (n > 1 && msg_len > ITEM_TARGET - 1 - requests_sent)
                msg_len = ITEM_TARGET - 1 - requests_sent;
            calm = (n == 2) || ($urandom_range(0, 4) == 0);
            repeat (msg_len) send_request(MODE_APPEND, 8'($urandom_range(0, 255)));
            if (n == 0) long_hold_req = 1;
            send_request(MODE_FINISH, 8'($urandom_range(0, 255)));
            if (n == 1) begin
                req_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
        end
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sha1_pkg.sv
src/sha1_in_if.sv
src/sha1_out_if.sv
src/sha1_datapath.sv
src/sha1_ctrl.sv
src/sha1_byte_stream_hasher.sv
test/tb_sha1_byte_stream_hasher.sv
